[rtl/core/bpme_pkg.sv]
package bpme_pkg;

  // Number of vertices emitted per box part, four per face.
  localparam int unsigned NUM_VERTS   = 24;
  localparam int unsigned VERT_IDX_W  = $clog2(NUM_VERTS);
  localparam int unsigned QUEUE_DEPTH = 2;

  // Face codes, which also stand for the face normal.
  localparam logic [2:0] FACE_FRONT  = 3'd0;
  localparam logic [2:0] FACE_BACK   = 3'd1;
  localparam logic [2:0] FACE_LEFT   = 3'd2;
  localparam logic [2:0] FACE_RIGHT  = 3'd3;
  localparam logic [2:0] FACE_TOP    = 3'd4;
  localparam logic [2:0] FACE_BOTTOM = 3'd5;

  // Texture coordinate selection codes.
  localparam logic [1:0] UV_ZERO  = 2'd0;
  localparam logic [1:0] UV_FIRST = 2'd1;
  localparam logic [1:0] UV_DEPTH = 2'd2;

  // One box part as it arrives on the input channel.
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic [30:0]        size_w;
    logic [30:0]        size_h;
    logic [30:0]        size_d;
    logic [7:0]         color_r;
    logic [7:0]         color_g;
    logic [7:0]         color_b;
  } in_item_t;

  // One vertex as it leaves on the output channel.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [28:0]        tex_u;
    logic [28:0]        tex_v;
    logic               tex_parity;
    logic [2:0]         face_code;
    logic [31:0]        vertex_number;
    logic               last_vertex;
  } out_item_t;

  // A classified part, held in the queue between front and back.
  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [29:0] hw;
    logic [29:0] hd;
    logic [30:0] h;
    logic [28:0] wq;
    logic [28:0] hq;
    logic [28:0] dq;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        parity;
  } job_t;

  // Corner description: sign of the x and z half extents, top or base,
  // and the texture coordinate selections.
  typedef struct packed {
    logic       sx;
    logic       sy;
    logic       sz;
    logic [1:0] us;
    logic [1:0] vs;
  } corner_t;

  function automatic corner_t corner_lut(input logic [VERT_IDX_W-1:0] k);
    corner_t c;
    c = '0;
    case (k)
      5'd0:  c = '{1'b0, 1'b0, 1'b1, UV_ZERO,  UV_ZERO};
      5'd1:  c = '{1'b1, 1'b0, 1'b1, UV_FIRST, UV_ZERO};
      5'd2:  c = '{1'b1, 1'b1, 1'b1, UV_FIRST, UV_FIRST};
      5'd3:  c = '{1'b0, 1'b1, 1'b1, UV_ZERO,  UV_FIRST};
      5'd4:  c = '{1'b1, 1'b0, 1'b0, UV_ZERO,  UV_ZERO};
      5'd5:  c = '{1'b0, 1'b0, 1'b0, UV_FIRST, UV_ZERO};
      5'd6:  c = '{1'b0, 1'b1, 1'b0, UV_FIRST, UV_FIRST};
      5'd7:  c = '{1'b1, 1'b1, 1'b0, UV_ZERO,  UV_FIRST};
      5'd8:  c = '{1'b0, 1'b0, 1'b0, UV_ZERO,  UV_ZERO};
      5'd9:  c = '{1'b0, 1'b0, 1'b1, UV_DEPTH, UV_ZERO};
      5'd10: c = '{1'b0, 1'b1, 1'b1, UV_DEPTH, UV_FIRST};
      5'd11: c = '{1'b0, 1'b1, 1'b0, UV_ZERO,  UV_FIRST};
      5'd12: c = '{1'b1, 1'b0, 1'b1, UV_ZERO,  UV_ZERO};
      5'd13: c = '{1'b1, 1'b0, 1'b0, UV_DEPTH, UV_ZERO};
      5'd14: c = '{1'b1, 1'b1, 1'b0, UV_DEPTH, UV_FIRST};
      5'd15: c = '{1'b1, 1'b1, 1'b1, UV_ZERO,  UV_FIRST};
      5'd16: c = '{1'b0, 1'b1, 1'b1, UV_ZERO,  UV_ZERO};
      5'd17: c = '{1'b1, 1'b1, 1'b1, UV_FIRST, UV_ZERO};
      5'd18: c = '{1'b1, 1'b1, 1'b0, UV_FIRST, UV_DEPTH};
      5'd19: c = '{1'b0, 1'b1, 1'b0, UV_ZERO,  UV_DEPTH};
      5'd20: c = '{1'b0, 1'b0, 1'b0, UV_ZERO,  UV_ZERO};
      5'd21: c = '{1'b1, 1'b0, 1'b0, UV_FIRST, UV_ZERO};
      5'd22: c = '{1'b1, 1'b0, 1'b1, UV_FIRST, UV_DEPTH};
      5'd23: c = '{1'b0, 1'b0, 1'b1, UV_ZERO,  UV_DEPTH};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/bpme_front.sv]
module bpme_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bpme_pkg::in_item_t in_data_i,
  output logic              push_o,
  output bpme_pkg::job_t    push_data_o,
  input  logic              q_full_i
);
  import bpme_pkg::*;

  // First stage: part centre and base height.
  logic        s1_valid_q;
  logic [31:0] s1_cx_q, s1_cy_q, s1_cz_q;
  logic [30:0] s1_w_q, s1_h_q, s1_d_q;
  logic [7:0]  s1_r_q, s1_g_q, s1_b_q;

  // Second stage: exact sum of the three centre values.
  logic        s2_valid_q;
  logic [31:0] s2_cx_q, s2_cy_q, s2_cz_q;
  logic [30:0] s2_w_q, s2_h_q, s2_d_q;
  logic [7:0]  s2_r_q, s2_g_q, s2_b_q;
  logic [33:0] s2_sum_q;

  logic        s1_load, s2_load;
  logic [33:0] sum_d;
  logic [33:0] rnd;

  // Flow control: a stage loads when it is empty or drains in the same cycle.
  assign push_o     = s2_valid_q && !q_full_i;
  assign s2_load    = s1_valid_q && (!s2_valid_q || push_o);
  assign in_stall_o = s1_valid_q && !s2_load;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_q <= 1'b1;
      end else if (push_o) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Centre sums wrap modulo 2^32.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_cx_q <= in_data_i.origin_x + in_data_i.offset_x;
      s1_cy_q <= in_data_i.origin_y + in_data_i.offset_y;
      s1_cz_q <= in_data_i.origin_z + in_data_i.offset_z;
      s1_w_q  <= in_data_i.size_w;
      s1_h_q  <= in_data_i.size_h;
      s1_d_q  <= in_data_i.size_d;
      s1_r_q  <= in_data_i.color_r;
      s1_g_q  <= in_data_i.color_g;
      s1_b_q  <= in_data_i.color_b;
    end
  end

  // Sign-extended three-way sum for the texture parity.
  assign sum_d = {{2{s1_cx_q[31]}}, s1_cx_q} + {{2{s1_cy_q[31]}}, s1_cy_q}
               + {{2{s1_cz_q[31]}}, s1_cz_q};

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_cx_q  <= s1_cx_q;
      s2_cy_q  <= s1_cy_q;
      s2_cz_q  <= s1_cz_q;
      s2_w_q   <= s1_w_q;
      s2_h_q   <= s1_h_q;
      s2_d_q   <= s1_d_q;
      s2_r_q   <= s1_r_q;
      s2_g_q   <= s1_g_q;
      s2_b_q   <= s1_b_q;
      s2_sum_q <= sum_d;
    end
  end

  // Round the magnitude half away from zero; for a negative sum the
  // negation and the rounding constant fold into one add.
  assign rnd = s2_sum_q[33] ? (~s2_sum_q + 34'h0_8001) : (s2_sum_q + 34'h0_8000);

  always_comb begin
    push_data_o        = '0;
    push_data_o.cx     = s2_cx_q;
    push_data_o.cy     = s2_cy_q;
    push_data_o.cz     = s2_cz_q;
    push_data_o.hw     = s2_w_q[30:1];
    push_data_o.hd     = s2_d_q[30:1];
    push_data_o.h      = s2_h_q;
    push_data_o.wq     = s2_w_q[30:2];
    push_data_o.hq     = s2_h_q[30:2];
    push_data_o.dq     = s2_d_q[30:2];
    push_data_o.red    = s2_r_q;
    push_data_o.green  = s2_g_q;
    push_data_o.blue   = s2_b_q;
    push_data_o.parity = rnd[16];
  end

endmodule

[rtl/core/bpme_queue.sv]
module bpme_queue #(
  parameter int unsigned QueueDepth = bpme_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bpme_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bpme_pkg::job_t head_o
);
  import bpme_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage for queued parts.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/bpme_back.sv]
module bpme_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  bpme_pkg::job_t     q_head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bpme_pkg::out_item_t out_data_o
);
  import bpme_pkg::*;

  localparam logic [VERT_IDX_W-1:0] LastIdx = VERT_IDX_W'(NUM_VERTS - 1);

  logic [VERT_IDX_W-1:0] k_q;
  logic [31:0]           vnum_q;
  logic                  out_valid_q;
  out_item_t             out_q, out_d;
  logic                  adv;
  corner_t               c;
  logic [2:0]            face;
  logic [28:0]           ufirst;

  // A vertex is produced whenever a part is queued and the output register frees.
  assign adv   = q_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = adv && (k_q == LastIdx);

  // Vertex generation for corner k of the head part.
  always_comb begin
    c      = corner_lut(k_q);
    face   = k_q[VERT_IDX_W-1:2];
    ufirst = q_head_i.wq;
    if (face inside {FACE_LEFT, FACE_RIGHT}) begin
      ufirst = q_head_i.dq;
    end
    out_d       = '0;
    out_d.pos_x = c.sx ? q_head_i.cx + {2'b00, q_head_i.hw} : q_head_i.cx - {2'b00, q_head_i.hw};
    out_d.pos_y = c.sy ? q_head_i.cy + {1'b0, q_head_i.h} : q_head_i.cy;
    out_d.pos_z = c.sz ? q_head_i.cz + {2'b00, q_head_i.hd} : q_head_i.cz - {2'b00, q_head_i.hd};
    out_d.red   = q_head_i.red;
    out_d.green = q_head_i.green;
    out_d.blue  = q_head_i.blue;
    case (c.us)
      UV_FIRST: out_d.tex_u = ufirst;
      UV_DEPTH: out_d.tex_u = q_head_i.dq;
      default:  out_d.tex_u = '0;
    endcase
    case (c.vs)
      UV_FIRST: out_d.tex_v = q_head_i.hq;
      UV_DEPTH: out_d.tex_v = q_head_i.dq;
      default:  out_d.tex_v = '0;
    endcase
    out_d.tex_parity    = q_head_i.parity;
    out_d.face_code     = face;
    out_d.vertex_number = vnum_q;
    out_d.last_vertex   = (k_q == LastIdx);
  end

  // Corner counter, running vertex number and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      vnum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        k_q         <= (k_q == LastIdx) ? '0 : k_q + 1'b1;
        vnum_q      <= vnum_q + 32'd1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/box_part_mesh_expander_unit.sv]
// A part goes through two front stages and the queue, then the output register.
// 24 vertices per part, one vertex per cycle while the output is not stalled.
// A two-stage front and a queue let the next part be taken while one is expanded.
// Reset (rst_ni, asynchronous, active low) empties all stages and the queue and
// clears the running vertex number to zero.
module box_part_mesh_expander_unit #(
  parameter int unsigned QueueDepth = bpme_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bpme_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bpme_pkg::out_item_t out_data_o
);
  import bpme_pkg::*;

  logic push, q_full, q_valid, pop;
  job_t push_data, q_head;

  // Front: centre sums and texture parity.
  bpme_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  // Queue of classified parts.
  bpme_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Back: vertex generation.
  bpme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // Within a part, vertices follow one another without a gap and are numbered in order.
  a_vertex_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_vertex |=>
      out_valid_o && (out_data_o.vertex_number == $past(out_data_o.vertex_number) + 32'd1))
    else $error("vertex run broken within a part");

  // The closing vertex of a part belongs to the bottom face.
  a_last_face : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_vertex |-> out_data_o.face_code == FACE_BOTTOM)
    else $error("last vertex not on the bottom face");

  // The back never pops an empty queue, and the front never pushes a full one.
  a_queue_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && !q_valid) && !(push && q_full))
    else $error("queue overrun or underrun");
`endif

endmodule
